@@ hdl/prtp_pkg.sv @@
// ----------------------------------------------------------------------------
// prtp_pkg
// Shared types and constants for the port range text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package prtp_pkg;

    localparam int unsigned CH_W      = 8;
    localparam int unsigned PORT_W    = 16;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned TDATA_W   = 48;
    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [PORT_W-1:0]  MAX_PORT  = 16'hFFFF;
    localparam logic [COUNT_W-1:0] MAX_COUNT = 8'hFF;

    localparam logic [CH_W-1:0] CH_SPACE  = 8'd32;
    localparam logic [CH_W-1:0] CH_TAB    = 8'd9;
    localparam logic [CH_W-1:0] CH_CR     = 8'd13;
    localparam logic [CH_W-1:0] CH_COLON  = 8'd58;
    localparam logic [CH_W-1:0] CH_DASH   = 8'd45;
    localparam logic [CH_W-1:0] CH_COMMA  = 8'd44;
    localparam logic [CH_W-1:0] CH_QUOTE  = 8'd34;
    localparam logic [CH_W-1:0] CH_NUL    = 8'd0;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'd48;
    localparam logic [CH_W-1:0] CH_NINE   = 8'd57;

    // classified character, as handed from front to back
    typedef struct packed {
        logic       is_ws;
        logic       is_sep;
        logic       is_digit;
        logic       is_term;
        logic       is_nul;
        logic [3:0] digit;
    } char_class_t;

    // parser phases
    typedef enum logic [5:0] {
        PH_SPACE   = 6'b000001,
        PH_UPONLY  = 6'b000010,
        PH_LOWER   = 6'b000100,
        PH_SEP     = 6'b001000,
        PH_UPPER   = 6'b010000,
        PH_DISCARD = 6'b100000
    } phase_t;

endpackage

`default_nettype wire

@@ hdl/port_range_text_parser.sv @@
// ----------------------------------------------------------------------------
// port_range_text_parser
// Parses a port range ("80", "1000-2000", ":443", "8000:") from a byte stream.
// ----------------------------------------------------------------------------
// The s_ channel takes one text byte per word; byte 0 ends a string. The m_
// channel gives one result word per parsed range or syntax error, carrying
// ok, lower and upper bound and the count of bytes consumed before the
// terminator. After a result, bytes up to the next byte 0 are dropped.
// Throughput is one byte per cycle while no result is held: the parser in
// the back unit updates its state once per byte. A byte is classified in
// the front unit and passes a four-word queue; the parser registers the
// result word from the deciding byte once it reads that byte from the queue.
// When the receiver stalls, the held result word blocks the parser, the
// queue fills behind it and s_tready drops once it holds four bytes; nothing
// is lost. A synchronous low aresetn empties the queue, drops any pending
// result and returns the parser to the leading whitespace phase.
// ----------------------------------------------------------------------------
`default_nettype none

module port_range_text_parser (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] ch
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [47:0]       m_tdata    // [0] ok, [16:1] lower_port,
                                         // [32:17] upper_port, [40:33] consumed
);

    logic                     q_valid;
    logic                     q_pop;
    prtp_pkg::char_class_t    q_data;

    // byte classification and queue
    prtp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    // range parser and result register
    prtp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

@@ hdl/prtp_front.sv @@
// ----------------------------------------------------------------------------
// prtp_front
// Accepts text words, classifies each byte and queues the class for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module prtp_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [prtp_pkg::CH_W-1:0]    s_tdata,
    output logic                              q_valid,
    output prtp_pkg::char_class_t             q_data,
    input  wire logic                         q_pop
);

    prtp_pkg::char_class_t                  cls;
    prtp_pkg::char_class_t                  mem [prtp_pkg::Q_DEPTH];
    logic [prtp_pkg::Q_PTR_W-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [prtp_pkg::Q_PTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [prtp_pkg::Q_CNT_W-1:0]           count_reg, count_next;
    logic                                   push;
    logic                                   pop;
    logic [prtp_pkg::CH_W-1:0]              digit_off;

    // byte classification
    always_comb begin
        digit_off    = s_tdata - prtp_pkg::CH_ZERO;
        cls.is_ws    = (s_tdata == prtp_pkg::CH_SPACE) ||
                       ((s_tdata >= prtp_pkg::CH_TAB) && (s_tdata <= prtp_pkg::CH_CR));
        cls.is_sep   = (s_tdata == prtp_pkg::CH_COLON) || (s_tdata == prtp_pkg::CH_DASH);
        cls.is_digit = (s_tdata >= prtp_pkg::CH_ZERO) && (s_tdata <= prtp_pkg::CH_NINE);
        cls.is_nul   = (s_tdata == prtp_pkg::CH_NUL);
        cls.is_term  = cls.is_ws || cls.is_nul ||
                       (s_tdata == prtp_pkg::CH_COMMA) || (s_tdata == prtp_pkg::CH_QUOTE);
        cls.digit    = digit_off[3:0];
    end

    // class queue control
    assign s_tready = (count_reg != prtp_pkg::Q_CNT_W'(prtp_pkg::Q_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_data   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

@@ hdl/prtp_back.sv @@
// ----------------------------------------------------------------------------
// prtp_back
// Runs the range parser on classified bytes and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module prtp_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    input  wire prtp_pkg::char_class_t         q_data,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [prtp_pkg::TDATA_W-1:0]       m_tdata
);

    prtp_pkg::phase_t                     phase_reg, phase_next;
    logic [prtp_pkg::PORT_W-1:0]          accum_reg, accum_next;
    logic [prtp_pkg::PORT_W-1:0]          lower_reg, lower_next;
    logic [prtp_pkg::COUNT_W-1:0]         count_reg, count_next;
    logic                                 seen_reg, seen_next;
    logic                                 m_valid_reg, m_valid_next;
    logic                                 ok_reg, ok_next;
    logic [prtp_pkg::PORT_W-1:0]          lo_reg, lo_next;
    logic [prtp_pkg::PORT_W-1:0]          hi_reg, hi_next;
    logic [prtp_pkg::COUNT_W-1:0]         cons_reg, cons_next;

    logic                                 fire;
    logic                                 emit;
    logic                                 good;
    logic [prtp_pkg::PORT_W-1:0]          res_lo;
    logic [prtp_pkg::PORT_W-1:0]          res_hi;
    logic [prtp_pkg::PORT_W+3:0]          acc_ten;
    logic                                 ovf;
    logic [prtp_pkg::COUNT_W-1:0]         count_inc;

    assign fire  = q_valid && (!m_valid_reg || m_tready);
    assign q_pop = fire;

    // accumulate one decimal digit
    always_comb begin
        acc_ten   = {accum_reg, 3'b000} + {2'b00, accum_reg, 1'b0}
                  + {(prtp_pkg::PORT_W)'(0), q_data.digit};
        ovf       = |acc_ten[prtp_pkg::PORT_W+3:prtp_pkg::PORT_W];
        count_inc = (count_reg == prtp_pkg::MAX_COUNT) ? count_reg : count_reg + 1'b1;
    end

    // parser next state
    always_comb begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        lower_next = lower_reg;
        count_next = count_reg;
        seen_next  = seen_reg;
        emit       = 1'b0;
        good       = 1'b0;
        res_lo     = '0;
        res_hi     = '0;

        unique case (phase_reg)
            prtp_pkg::PH_SPACE: begin
                if (q_data.is_ws) begin
                    count_next = count_inc;
                end else if (q_data.is_sep) begin
                    count_next = count_inc;
                    accum_next = '0;
                    seen_next  = 1'b0;
                    phase_next = prtp_pkg::PH_UPONLY;
                end else if (q_data.is_digit) begin
                    accum_next = {(prtp_pkg::PORT_W-4)'(0), q_data.digit};
                    seen_next  = 1'b1;
                    count_next = count_inc;
                    phase_next = prtp_pkg::PH_LOWER;
                end else begin
                    emit = 1'b1;
                end
            end
            prtp_pkg::PH_UPONLY: begin
                if (q_data.is_digit) begin
                    if (ovf) begin
                        emit = 1'b1;
                    end else begin
                        accum_next = acc_ten[prtp_pkg::PORT_W-1:0];
                        seen_next  = 1'b1;
                        count_next = count_inc;
                    end
                end else begin
                    emit   = 1'b1;
                    good   = seen_reg && q_data.is_term;
                    res_lo = '0;
                    res_hi = accum_reg;
                end
            end
            prtp_pkg::PH_LOWER: begin
                if (q_data.is_digit) begin
                    if (ovf) begin
                        emit = 1'b1;
                    end else begin
                        accum_next = acc_ten[prtp_pkg::PORT_W-1:0];
                        seen_next  = 1'b1;
                        count_next = count_inc;
                    end
                end else if (q_data.is_sep) begin
                    lower_next = accum_reg;
                    count_next = count_inc;
                    phase_next = prtp_pkg::PH_SEP;
                end else begin
                    emit   = 1'b1;
                    good   = q_data.is_term;
                    res_lo = accum_reg;
                    res_hi = accum_reg;
                end
            end
            prtp_pkg::PH_SEP: begin
                if (q_data.is_digit) begin
                    accum_next = {(prtp_pkg::PORT_W-4)'(0), q_data.digit};
                    seen_next  = 1'b1;
                    count_next = count_inc;
                    phase_next = prtp_pkg::PH_UPPER;
                end else begin
                    emit   = 1'b1;
                    good   = q_data.is_term;
                    res_lo = lower_reg;
                    res_hi = prtp_pkg::MAX_PORT;
                end
            end
            prtp_pkg::PH_UPPER: begin
                if (q_data.is_digit) begin
                    if (ovf) begin
                        emit = 1'b1;
                    end else begin
                        accum_next = acc_ten[prtp_pkg::PORT_W-1:0];
                        seen_next  = 1'b1;
                        count_next = count_inc;
                    end
                end else begin
                    emit = 1'b1;
                    good = q_data.is_term;
                    // order the two bounds
                    if (lower_reg > accum_reg) begin
                        res_lo = accum_reg;
                        res_hi = lower_reg;
                    end else begin
                        res_lo = lower_reg;
                        res_hi = accum_reg;
                    end
                end
            end
            prtp_pkg::PH_DISCARD: begin
                if (q_data.is_nul) begin
                    phase_next = prtp_pkg::PH_SPACE;
                end
            end
            default: begin
                phase_next = prtp_pkg::PH_SPACE;
            end
        endcase

        // result ends the parse; discard unless the string ended here
        if (emit) begin
            accum_next = '0;
            lower_next = '0;
            count_next = '0;
            seen_next  = 1'b0;
            phase_next = q_data.is_nul ? prtp_pkg::PH_SPACE : prtp_pkg::PH_DISCARD;
        end
    end

    // output word register
    always_comb begin
        m_valid_next = m_valid_reg;
        ok_next      = ok_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        cons_next    = cons_reg;
        if (fire && emit) begin
            m_valid_next = 1'b1;
            ok_next      = good;
            lo_next      = good ? res_lo : '0;
            hi_next      = good ? res_hi : '0;
            cons_next    = good ? count_reg : '0;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= prtp_pkg::PH_SPACE;
            accum_reg   <= '0;
            lower_reg   <= '0;
            count_reg   <= '0;
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (fire) begin
                phase_reg <= phase_next;
                accum_reg <= accum_next;
                lower_reg <= lower_next;
                count_reg <= count_next;
                seen_reg  <= seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg   <= ok_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        cons_reg <= cons_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, cons_reg, hi_reg, lo_reg, ok_reg};

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream test of the port range text parser: text bytes with random gaps,
// results taken with random stalls and checked against a local parser model.
// ----------------------------------------------------------------------------

module tb;
    import prtp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;

    // one parsed range as carried by the result word
    typedef struct packed {
        logic              ok;
        logic [PORT_W-1:0] lower;
        logic [PORT_W-1:0] upper;
        logic [7:0]        used;
    } port_range_t;

    // one pending text byte; hold makes the sender wait for all results first
    typedef struct packed {
        logic [7:0] ch;
        logic       hold;
    } text_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    text_byte_t  text_q[$];
    port_range_t range_q[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    logic        hold_next = 1'b0;

    // local parser state
    phase_t      parse_ph;
    logic [16:0] num_acc;
    logic [15:0] low_bound;
    logic [7:0]  used_cnt;
    logic        got_digit;

    // sender and receiver pacing
    int          gap_left = 0;
    int          stall_left = 0;
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;

    port_range_text_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------
    function automatic bit is_ws(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_sep(input logic [7:0] c);
        return c == CH_COLON || c == CH_DASH;
    endfunction

    function automatic bit is_term(input logic [7:0] c);
        return is_ws(c) || c == CH_COMMA || c == CH_QUOTE || c == CH_NUL;
    endfunction

    task automatic clear_parse();
        parse_ph  = PH_SPACE;
        num_acc   = '0;
        low_bound = '0;
        used_cnt  = '0;
        got_digit = 1'b0;
    endtask

    function automatic void bump_count();
        if (used_cnt != MAX_COUNT) begin
            used_cnt = used_cnt + 8'd1;
        end
    endfunction

    // appends a digit, refusing values above the port range
    function automatic bit take_digit(input logic [7:0] c);
        logic [31:0] v;
        v = 32'(num_acc) * 32'd10 + 32'(c) - 32'(CH_ZERO);
        if (v > 32'(MAX_PORT)) begin
            return 1'b0;
        end
        num_acc   = v[16:0];
        got_digit = 1'b1;
        bump_count();
        return 1'b1;
    endfunction

    // queue the decided range; an error clears every field
    task automatic close_range(input logic [7:0] c, input logic good,
                               input logic [15:0] lo, input logic [15:0] hi);
        port_range_t r;
        r.ok    = good;
        r.lower = good ? lo : '0;
        r.upper = good ? hi : '0;
        r.used  = good ? used_cnt : '0;
        range_q.push_back(r);
        clear_parse();
        if (c != CH_NUL) begin
            parse_ph = PH_DISCARD;
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic [15:0] a;
        logic [15:0] b;
        case (parse_ph)
            PH_SPACE: begin
                if (is_ws(c)) begin
                    bump_count();
                end else if (is_sep(c)) begin
                    bump_count();
                    num_acc   = '0;
                    got_digit = 1'b0;
                    parse_ph  = PH_UPONLY;
                end else if (is_digit(c)) begin
                    num_acc = '0;
                    void'(take_digit(c));
                    parse_ph = PH_LOWER;
                end else begin
                    close_range(c, 1'b0, '0, '0);
                end
            end
            PH_UPONLY: begin
                if (is_digit(c)) begin
                    if (!take_digit(c)) close_range(c, 1'b0, '0, '0);
                end else if (!got_digit || !is_term(c)) begin
                    close_range(c, 1'b0, '0, '0);
                end else begin
                    close_range(c, 1'b1, '0, num_acc[15:0]);
                end
            end
            PH_LOWER: begin
                if (is_digit(c)) begin
                    if (!take_digit(c)) close_range(c, 1'b0, '0, '0);
                end else begin
                    low_bound = num_acc[15:0];
                    if (is_sep(c)) begin
                        bump_count();
                        parse_ph = PH_SEP;
                    end else if (!is_term(c)) begin
                        close_range(c, 1'b0, '0, '0);
                    end else begin
                        close_range(c, 1'b1, low_bound, low_bound);
                    end
                end
            end
            PH_SEP: begin
                if (is_digit(c)) begin
                    num_acc   = '0;
                    got_digit = 1'b0;
                    void'(take_digit(c));
                    parse_ph = PH_UPPER;
                end else if (!is_term(c)) begin
                    close_range(c, 1'b0, '0, '0);
                end else begin
                    close_range(c, 1'b1, low_bound, MAX_PORT);
                end
            end
            PH_UPPER: begin
                if (is_digit(c)) begin
                    if (!take_digit(c)) close_range(c, 1'b0, '0, '0);
                end else if (!is_term(c)) begin
                    close_range(c, 1'b0, '0, '0);
                end else begin
                    // a reversed pair is put in order
                    a = low_bound;
                    b = num_acc[15:0];
                    if (a > b) close_range(c, 1'b1, b, a);
                    else close_range(c, 1'b1, a, b);
                end
            end
            default: begin
                if (c == CH_NUL) clear_parse();
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] c);
        text_byte_t t;
        t.ch = c;
        t.hold = hold_next;
        text_q.push_back(t);
        hold_next = 1'b0;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_byte(s[i]);
        end
    endtask

    function automatic logic [7:0] ws_char();
        return $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
    endfunction

    function automatic logic [7:0] sep_char();
        return $urandom_range(0, 1) ? CH_COLON : CH_DASH;
    endfunction

    function automatic string num_text();
        case ($urandom_range(0, 11))
            0:       return "0";
            1:       return "65535";
            2:       return $sformatf("%0d", $urandom_range(65536, 99999));
            3:       return {"00", $sformatf("%0d", $urandom_range(0, 65535))};
            4:       return "";
            5, 6:    return $sformatf("%0d", $urandom_range(0, 99));
            default: return $sformatf("%0d", $urandom_range(0, 65535));
        endcase
    endfunction

    // terminator, then junk up to byte 0 when the string goes on
    task automatic end_string();
        logic [7:0] t;
        case ($urandom_range(0, 7))
            0, 1:    t = CH_NUL;
            2:       t = CH_COMMA;
            3:       t = CH_QUOTE;
            4, 5:    t = ws_char();
            default: t = 8'($urandom_range(0, 255));
        endcase
        push_byte(t);
        if (t != CH_NUL) begin
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(1, 255)));
            push_byte(CH_NUL);
        end
    endtask

    task automatic add_random_string(input bit long_lead);
        int n;
        n = long_lead ? $urandom_range(250, 260) : $urandom_range(0, 2);
        repeat (n) push_byte(ws_char());
        case ($urandom_range(0, 9))
            0, 1: begin
                push_byte(sep_char());
                push_text(num_text());
            end
            2, 3, 4: begin
                push_text(num_text());
                push_byte(sep_char());
                push_text(num_text());
            end
            5, 6: begin
                push_text(num_text());
                push_byte(sep_char());
            end
            7, 8: push_text(num_text());
            default: repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
        endcase
        end_string();
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // driver: one text word from the queue, with a drawn gap after each
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic       next_valid;
        logic [7:0] next_data;
        text_byte_t t;
        if (aresetn) begin
            next_valid = s_tvalid;
            next_data  = s_tdata;
            if (s_tvalid && s_tready) begin
                parse_char(s_tdata);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (text_q.size() != 0 &&
                             !(text_q[0].hold && range_q.size() != 0)) begin
                    t = text_q.pop_front();
                    next_valid = 1'b1;
                    next_data  = t.ch;
                    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
                    gap_left = tx_calm ? 0 : $urandom_range(0, 5);
                end
            end
            s_tvalid <= next_valid;
            s_tdata  <= next_data;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: compare each result word with the oldest expected range
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        port_range_t got;
        port_range_t want;
        logic        rdy;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.ok    = m_tdata[0];
                got.lower = m_tdata[16:1];
                got.upper = m_tdata[32:17];
                got.used  = m_tdata[40:33];
                if (range_q.size() == 0) begin
                    report_mismatch("unexpected result, ok", got.ok, 0);
                end else begin
                    want = range_q.pop_front();
                    if (got.ok !== want.ok) report_mismatch("ok", got.ok, want.ok);
                    if (got.lower !== want.lower)
                        report_mismatch("lower_port", got.lower, want.lower);
                    if (got.upper !== want.upper)
                        report_mismatch("upper_port", got.upper, want.upper);
                    if (got.used !== want.used)
                        report_mismatch("consumed", got.used, want.used);
                end
                if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
                stall_left = rx_calm ? 0 : $urandom_range(0, 5);
            end
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        clear_parse();

        // reversed pair at both extremes, decided on byte 0
        push_text("65535-0");
        push_byte(CH_NUL);
        // overflow, high byte dropped while discarding, byte 0 ends discard
        push_text("65536");
        push_byte(8'hFF);
        push_byte(CH_NUL);
        // separator with an empty number
        push_text(" :,");
        push_byte(CH_NUL);
        // open upper bound ended by a quote, then junk
        push_text("9:\"x");
        push_byte(CH_NUL);

        // wait for the directed results before random traffic
        hold_next = 1'b1;
        add_random_string(1'b1);
        while (text_q.size() < 520) begin
            if (text_q.size() > 250 && text_q.size() < 260) hold_next = 1'b1;
            add_random_string($urandom_range(0, 99) == 0);
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (text_q.size() != 0 || s_tvalid || range_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && range_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
